FILE: rtl/core/tets_pkg.sv
// Shared types and constants of the tick-driven task scheduler.
// Used by the channel interfaces, the event evaluator and the top level.
`default_nettype none

package tets_pkg;

  // Fixed widths of the item fields
  localparam int unsigned TASK_IDX_W   = 3;
  localparam int unsigned PRIO_W       = 2;
  localparam int unsigned REL_TIME_W   = 8;
  localparam int unsigned DELAY_W      = 8;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned OUT_TASK_W   = 4;

  // Event bits that can be posted to a task
  localparam int unsigned EV_W     = 2;
  localparam int unsigned EV_ABS   = 0;
  localparam int unsigned EV_DELAY = 1;

  // Item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Parameter defaults
  localparam int unsigned NUM_TASKS_DEF       = 8;
  localparam int unsigned NUM_CLASSES_DEF     = 4;
  localparam int unsigned TASKS_PER_CLASS_DEF = 8;
  localparam int unsigned TIME_BITS_DEF       = 8;

  // Per-task wait record
  typedef struct packed {
    logic [PRIO_W-1:0]     prio;
    logic [REL_TIME_W-1:0] rel_time;
    logic [DELAY_W-1:0]    delay;
    logic [EV_W-1:0]       posted;
    logic [MASK_W-1:0]     mask;
    logic                  wait_any;
  } tets_rec_t;

  // Record contents of a task that was never loaded
  localparam tets_rec_t REC_RESET = '{
    prio:     '0,
    rel_time: '0,
    delay:    '0,
    posted:   '0,
    mask:     MASK_W'(1),
    wait_any: 1'b1
  };

endpackage

`default_nettype wire

FILE: rtl/core/tets_in_if.sv
// Input channel of the task scheduler: valid/ready handshake plus one item.
// Depends on tets_pkg for the field widths.
`default_nettype none

interface tets_in_if
  import tets_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [TASK_IDX_W-1:0] task_index;
  logic [PRIO_W-1:0]     priority_class;
  logic [REL_TIME_W-1:0] release_time;
  logic [DELAY_W-1:0]    delay_ticks;
  logic [MASK_W-1:0]     wait_mask;
  logic                  wait_any;

  modport source (
    output valid, mode, task_index, priority_class, release_time, delay_ticks,
           wait_mask, wait_any,
    input  ready
  );

  modport sink (
    input  valid, mode, task_index, priority_class, release_time, delay_ticks,
           wait_mask, wait_any,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/tets_out_if.sv
// Result channel of the task scheduler: valid/ready handshake plus one item.
// Depends on tets_pkg for the field widths.
`default_nettype none

interface tets_out_if
  import tets_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  switch_needed;
  logic [OUT_TASK_W-1:0] running_task;
  logic [OUT_TASK_W-1:0] left_task;

  modport source (
    output valid, switch_needed, running_task, left_task,
    input  ready
  );

  modport sink (
    input  valid, switch_needed, running_task, left_task,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/tets_eval.sv
// Tick evaluation of one task wait record: posts timer and delay events,
// counts the delay down and decides whether the task is released. Uses tets_pkg.
`default_nettype none

module tets_eval
  import tets_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] tick_time_i,
  input  tets_rec_t            rec_i,
  output tets_rec_t            rec_o,
  output logic                 ready_o
);

  logic [EV_W-1:0] hits;

  always_comb begin
    rec_o = rec_i;
    // post the absolute timer event on a time match
    if (tick_time_i == TIME_BITS'(rec_i.rel_time)) begin
      rec_o.posted[EV_ABS] = 1'b1;
    end
    // count the delay down, post when it reaches zero
    if (rec_i.delay != '0) begin
      rec_o.delay = rec_i.delay - 1'b1;
      if (rec_i.delay == DELAY_W'(1)) begin
        rec_o.posted[EV_DELAY] = 1'b1;
      end
    end
    // any-of or all-of release against the mask
    hits = rec_o.posted & rec_i.mask[EV_W-1:0];
    if (rec_i.wait_any) begin
      ready_o = (hits != '0);
    end else begin
      ready_o = (rec_i.mask[MASK_W-1:EV_W] == '0) && (hits == rec_i.mask[EV_W-1:0]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tick_event_task_scheduler.sv
// Tick-driven fixed-priority task scheduler, top level.
// Depends on tets_pkg, tets_in_if, tets_out_if and tets_eval.
//
// Usage:
//   in_i carries items. mode 0 is a timer tick: the time counter advances and
//   every suspended task is checked for its events. mode 1 loads the wait
//   record of task_index, pulls the task off its due list and suspends it.
//   out_o returns exactly one item per input item: the switch flag, the task
//   now running (NUM_TASKS is the idle task) and the task left behind.
//   Task records sit in a memory of NUM_TASKS entries, the due lists in a
//   memory of NUM_CLASSES x 2**SLOT_W slots; both have a registered read.
// Sequencing:
//   A tick reads the record of each suspended task and writes it back, then
//   picks the running task when a task became due. A load searches the due
//   list of the task, if it is due, slot by slot, moves each entry behind it
//   down one slot, stores the record and picks the running task.
//   One item is in work at a time; the next one is accepted as soon as the
//   result is in the output register, which holds it while out_o stalls.
// Reset:
//   All tasks are suspended in index order with an absolute timer wait at time
//   zero, the time counter is all ones and the idle task runs.
`default_nettype none

module tick_event_task_scheduler
  import tets_pkg::*;
#(
  parameter int unsigned NUM_TASKS       = NUM_TASKS_DEF,
  parameter int unsigned NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int unsigned TASKS_PER_CLASS = TASKS_PER_CLASS_DEF,
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tets_in_if.sink     in_i,
  tets_out_if.source  out_o
);

  localparam int unsigned TASK_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned ID_W     = $clog2(NUM_TASKS + 1);
  localparam int unsigned CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SLOT_W   = (TASKS_PER_CLASS > 1) ? $clog2(TASKS_PER_CLASS) : 1;
  localparam int unsigned DCNT_W   = $clog2(TASKS_PER_CLASS + 1);
  localparam int unsigned DUE_AW   = CLS_W + SLOT_W;
  localparam int unsigned DUE_DEPTH = NUM_CLASSES * (2 ** SLOT_W);
  localparam logic [ID_W-1:0]   IDLE_ID  = ID_W'(NUM_TASKS);
  localparam logic [DCNT_W-1:0] CLS_FULL = DCNT_W'(TASKS_PER_CLASS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_EV,
    S_PICK,
    S_PICK_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LOAD,
    S_FIN
  } state_e;

  state_e state_q;

  // Control and list state
  logic [TIME_BITS-1:0] tick_q;
  logic [TASK_W-1:0]    susp_q     [NUM_TASKS];
  logic [ID_W-1:0]      scnt_q;
  logic [NUM_TASKS-1:0] susp_bit_q;
  logic [NUM_TASKS-1:0] in_due_q;
  logic [CLS_W-1:0]     due_cls_q  [NUM_TASKS];
  logic [DCNT_W-1:0]    due_cnt_q  [NUM_CLASSES];
  logic [NUM_TASKS-1:0] rec_vld_q;
  logic [ID_W-1:0]      active_q;
  logic [ID_W-1:0]      prev_q;
  logic                 sw_q;
  logic                 became_q;
  logic [ID_W-1:0]      walk_idx_q;
  logic [DCNT_W-1:0]    slot_q;
  logic [CLS_W-1:0]     srch_cls_q;
  logic [TASK_W-1:0]    cur_t_q;
  tets_rec_t            cur_rec_q;

  // Output register
  logic                  out_vld_q;
  logic                  out_sw_q;
  logic [OUT_TASK_W-1:0] out_run_q;
  logic [OUT_TASK_W-1:0] out_left_q;

  // Memories and their ports
  tets_rec_t         rec_mem [NUM_TASKS];
  tets_rec_t         rec_rdata_q;
  logic              rec_rvld_q;
  logic [TASK_W-1:0] rec_raddr;
  logic              rec_we;
  logic [TASK_W-1:0] rec_waddr;
  tets_rec_t         rec_wdata;
  tets_rec_t         rec_eff;

  logic [TASK_W-1:0] due_mem [DUE_DEPTH];
  logic [TASK_W-1:0] due_rdata_q;
  logic [DUE_AW-1:0] due_raddr;
  logic              due_we;
  logic [DUE_AW-1:0] due_waddr;
  logic [TASK_W-1:0] due_wdata;

  // Evaluation and selection
  tets_rec_t         ev_rec;
  logic              ev_ready;
  logic [CLS_W-1:0]  ev_cls;
  logic              ev_take;
  logic              pick_found;
  logic [CLS_W-1:0]  pick_cls;
  logic [DCNT_W-1:0] slot_nxt;
  logic [DCNT_W-1:0] srch_cnt;
  logic              in_fire;
  logic              out_fire;
  logic [TASK_W-1:0] in_t;
  logic [PRIO_W-1:0] in_prio;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign out_o.valid         = out_vld_q;
  assign out_o.switch_needed = out_sw_q;
  assign out_o.running_task  = out_run_q;
  assign out_o.left_task     = out_left_q;

  assign in_t    = TASK_W'(in_i.task_index);
  assign in_prio = (32'(in_i.priority_class) >= NUM_CLASSES) ?
                   PRIO_W'(NUM_CLASSES - 1) : in_i.priority_class;

  // Task record read; a never-loaded entry reads as the reset record
  assign rec_eff = rec_rvld_q ? rec_rdata_q : REC_RESET;

  tets_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .tick_time_i (tick_q),
    .rec_i       (rec_eff),
    .rec_o       (ev_rec),
    .ready_o     (ev_ready)
  );

  assign ev_cls   = CLS_W'(rec_eff.prio);
  assign ev_take  = ev_ready && (due_cnt_q[ev_cls] < CLS_FULL);
  assign slot_nxt = slot_q + 1'b1;
  assign srch_cnt = due_cnt_q[srch_cls_q];

  // Find the highest non-empty class
  always_comb begin
    pick_found = 1'b0;
    pick_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (due_cnt_q[c] != '0) begin
        pick_found = 1'b1;
        pick_cls   = CLS_W'(c);
      end
    end
  end

  // Drive the memory ports from the sequencer state
  always_comb begin
    rec_raddr = susp_q[walk_idx_q[TASK_W-1:0]];
    rec_we    = 1'b0;
    rec_waddr = cur_t_q;
    rec_wdata = ev_rec;
    due_raddr = {srch_cls_q, slot_q[SLOT_W-1:0]};
    due_we    = 1'b0;
    due_waddr = {srch_cls_q, slot_q[SLOT_W-1:0]};
    due_wdata = due_rdata_q;
    case (state_q)
      S_WALK_EV: begin
        rec_we = 1'b1;
        if (ev_take) begin
          due_we    = 1'b1;
          due_waddr = {ev_cls, due_cnt_q[ev_cls][SLOT_W-1:0]};
          due_wdata = cur_t_q;
        end
      end
      S_LOAD: begin
        rec_we    = 1'b1;
        rec_wdata = cur_rec_q;
      end
      S_PICK: begin
        due_raddr = {pick_cls, {SLOT_W{1'b0}}};
      end
      S_SHIFT_RD: begin
        due_raddr = {srch_cls_q, slot_nxt[SLOT_W-1:0]};
      end
      S_SHIFT_WR: begin
        due_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Task record memory
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata_q <= rec_mem[rec_raddr];
    rec_rvld_q  <= rec_vld_q[rec_raddr];
  end

  // Due list memory
  always_ff @(posedge clk_i) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    due_rdata_q <= due_mem[due_raddr];
  end

  // Sequencer, list bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tick_q     <= '1;
      scnt_q     <= ID_W'(NUM_TASKS);
      susp_bit_q <= '1;
      in_due_q   <= '0;
      rec_vld_q  <= '0;
      active_q   <= IDLE_ID;
      prev_q     <= IDLE_ID;
      sw_q       <= 1'b0;
      became_q   <= 1'b0;
      walk_idx_q <= '0;
      slot_q     <= '0;
      srch_cls_q <= '0;
      cur_t_q    <= '0;
      cur_rec_q  <= REC_RESET;
      out_vld_q  <= 1'b0;
      out_sw_q   <= 1'b0;
      out_run_q  <= '0;
      out_left_q <= '0;
      for (int k = 0; k < NUM_TASKS; k++) begin
        susp_q[k]    <= TASK_W'(k);
        due_cls_q[k] <= '0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        due_cnt_q[c] <= '0;
      end
    end else begin
      if (rec_we) begin
        rec_vld_q[rec_waddr] <= 1'b1;
      end
      if (out_fire) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        // accept an item and dispatch on its mode
        S_IDLE: begin
          if (in_fire) begin
            cur_t_q   <= in_t;
            cur_rec_q <= '{
              prio:     in_prio,
              rel_time: in_i.release_time,
              delay:    in_i.delay_ticks,
              posted:   '0,
              mask:     in_i.wait_mask,
              wait_any: in_i.wait_any
            };
            if (in_i.mode == MODE_TICK) begin
              tick_q     <= tick_q + 1'b1;
              walk_idx_q <= '0;
              became_q   <= 1'b0;
              state_q    <= S_WALK_RD;
            end else if (32'(in_i.task_index) < NUM_TASKS) begin
              if (in_due_q[in_t]) begin
                srch_cls_q <= due_cls_q[in_t];
                slot_q     <= '0;
                state_q    <= S_SRCH_RD;
              end else begin
                state_q <= S_LOAD;
              end
            end else begin
              sw_q    <= 1'b0;
              state_q <= S_FIN;
            end
          end
        end
        // read the record of the next suspended task
        S_WALK_RD: begin
          if (walk_idx_q < scnt_q) begin
            cur_t_q <= susp_q[walk_idx_q[TASK_W-1:0]];
            state_q <= S_WALK_EV;
          end else if (became_q) begin
            state_q <= S_PICK;
          end else begin
            sw_q    <= 1'b0;
            state_q <= S_FIN;
          end
        end
        // write back events; move a released task to its due list
        S_WALK_EV: begin
          if (ev_take) begin
            due_cnt_q[ev_cls]   <= due_cnt_q[ev_cls] + 1'b1;
            scnt_q              <= scnt_q - 1'b1;
            susp_bit_q[cur_t_q] <= 1'b0;
            in_due_q[cur_t_q]   <= 1'b1;
            due_cls_q[cur_t_q]  <= ev_cls;
            became_q            <= 1'b1;
            for (int u = 0; u < NUM_TASKS - 1; u++) begin
              if (ID_W'(u) >= walk_idx_q) begin
                susp_q[u] <= susp_q[u + 1];
              end
            end
          end else begin
            walk_idx_q <= walk_idx_q + 1'b1;
          end
          state_q <= S_WALK_RD;
        end
        // select the head of the highest non-empty class
        S_PICK: begin
          prev_q <= active_q;
          if (pick_found) begin
            state_q <= S_PICK_WAIT;
          end else begin
            active_q <= IDLE_ID;
            sw_q     <= (active_q != IDLE_ID);
            state_q  <= S_FIN;
          end
        end
        S_PICK_WAIT: begin
          active_q <= ID_W'(due_rdata_q);
          sw_q     <= (ID_W'(due_rdata_q) != active_q);
          state_q  <= S_FIN;
        end
        // search the due list for the task being reloaded
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (due_rdata_q == cur_t_q) begin
            due_cnt_q[srch_cls_q] <= srch_cnt - 1'b1;
            state_q               <= S_SHIFT_RD;
          end else if (slot_nxt >= srch_cnt) begin
            state_q <= S_LOAD;
          end else begin
            slot_q  <= slot_nxt;
            state_q <= S_SRCH_RD;
          end
        end
        // close the gap: move each later entry down one slot
        S_SHIFT_RD: begin
          if (slot_q < srch_cnt) begin
            state_q <= S_SHIFT_WR;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_SHIFT_WR: begin
          slot_q  <= slot_nxt;
          state_q <= S_SHIFT_RD;
        end
        // store the new record and suspend the task
        S_LOAD: begin
          in_due_q[cur_t_q] <= 1'b0;
          if (!susp_bit_q[cur_t_q] && (scnt_q < ID_W'(NUM_TASKS))) begin
            susp_q[scnt_q[TASK_W-1:0]] <= cur_t_q;
            scnt_q                     <= scnt_q + 1'b1;
            susp_bit_q[cur_t_q]        <= 1'b1;
          end
          state_q <= S_PICK;
        end
        // hand the result to the output register once it is free
        S_FIN: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q  <= 1'b1;
            out_sw_q   <= sw_q;
            out_run_q  <= OUT_TASK_W'(active_q);
            out_left_q <= OUT_TASK_W'(prev_q);
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The suspended count never exceeds the number of tasks
  a_scnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= ID_W'(NUM_TASKS))
    else $error("suspended count out of range");

  // Membership bits agree with the suspended count
  a_scnt_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(susp_bit_q) == int'(scnt_q))
    else $error("suspended membership and count disagree");

  // A task is never suspended and due at the same time
  a_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (susp_bit_q & in_due_q) == '0)
    else $error("task both suspended and due");

  // A new result only ever comes from the finishing state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_FIN))
    else $error("result posted outside the finishing state");

endmodule

`default_nettype wire

FILE: tb/tets_sched_checker.sv
// Scoreboard of the tick-driven task scheduler: predicts one result per item.
// Watches tets_in_if and tets_out_if; takes widths and event bits from tets_pkg.

module tets_sched_checker
  import tets_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tets_in_if           in_ch,
  tets_out_if          out_ch,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  localparam int unsigned N_TASKS   = NUM_TASKS_DEF;
  localparam int unsigned N_CLASSES = NUM_CLASSES_DEF;
  localparam int unsigned PER_CLASS = TASKS_PER_CLASS_DEF;
  localparam logic [OUT_TASK_W-1:0] IDLE_TASK   = OUT_TASK_W'(NUM_TASKS_DEF);
  localparam logic [MASK_W-1:0]     ABS_EVENT   = MASK_W'(1) << EV_ABS;
  localparam logic [MASK_W-1:0]     DELAY_EVENT = MASK_W'(1) << EV_DELAY;

  typedef struct packed {
    logic                  switch_needed;
    logic [OUT_TASK_W-1:0] running_task;
    logic [OUT_TASK_W-1:0] left_task;
  } sched_result_t;

  // Predicted scheduler state
  logic [TIME_BITS_DEF-1:0] sched_time;
  logic [REL_TIME_W-1:0]    rec_rel    [N_TASKS];
  logic [DELAY_W-1:0]       rec_delay  [N_TASKS];
  logic [MASK_W-1:0]        rec_posted [N_TASKS];
  logic [MASK_W-1:0]        rec_mask   [N_TASKS];
  logic                     rec_any    [N_TASKS];
  logic [PRIO_W-1:0]        rec_prio   [N_TASKS];
  int unsigned              suspended_q[$];
  int unsigned              due_q      [N_CLASSES][$];
  logic [OUT_TASK_W-1:0]    running_now;
  logic [OUT_TASK_W-1:0]    left_now;

  sched_result_t sched_results_q[$];
  int unsigned   fail_cnt;

  // Return to the state after reset: all tasks suspended, idle task running
  function automatic void reset_schedule();
    int unsigned t, c;
    sched_time = '1;
    suspended_q.delete();
    for (t = 0; t < N_TASKS; t++) begin
      rec_rel[t]    = '0;
      rec_delay[t]  = '0;
      rec_posted[t] = '0;
      rec_mask[t]   = ABS_EVENT;
      rec_any[t]    = 1'b1;
      rec_prio[t]   = '0;
      suspended_q.push_back(t);
    end
    for (c = 0; c < N_CLASSES; c++) due_q[c].delete();
    running_now = IDLE_TASK;
    left_now    = IDLE_TASK;
  endfunction

  // Head of the highest non-empty class runs; idle if all are empty
  function automatic void pick_running();
    int c;
    left_now    = running_now;
    running_now = IDLE_TASK;
    for (c = N_CLASSES - 1; c >= 0; c--) begin
      if (due_q[c].size() != 0) begin
        running_now = OUT_TASK_W'(due_q[c][0]);
        break;
      end
    end
  endfunction

  // Advance time, post events and move released tasks to their due lists
  function automatic bit advance_tick();
    int unsigned       i, t, p;
    logic [MASK_W-1:0] hits;
    bit                met;
    bit                released;
    released   = 1'b0;
    i          = 0;
    sched_time = sched_time + 1'b1;
    while (i < suspended_q.size()) begin
      t = suspended_q[i];
      if (sched_time == rec_rel[t]) rec_posted[t] |= ABS_EVENT;
      if (rec_delay[t] != 0) begin
        rec_delay[t] = rec_delay[t] - 1'b1;
        if (rec_delay[t] == 0) rec_posted[t] |= DELAY_EVENT;
      end
      hits = rec_posted[t] & rec_mask[t];
      met  = rec_any[t] ? (hits != 0) : (hits == rec_mask[t]);
      p    = rec_prio[t];
      // A released task leaves; the entry shifted into slot i is checked next
      if (met && due_q[p].size() < PER_CLASS) begin
        due_q[p].push_back(t);
        suspended_q.delete(i);
        released = 1'b1;
      end else begin
        i++;
      end
    end
    return released;
  endfunction

  // Load a wait record: pull the task off its due list and suspend it once
  function automatic void load_record(input logic [TASK_IDX_W-1:0] t,
                                      input logic [PRIO_W-1:0]     prio,
                                      input logic [REL_TIME_W-1:0] rel,
                                      input logic [DELAY_W-1:0]    delay,
                                      input logic [MASK_W-1:0]     mask,
                                      input logic                  any);
    int unsigned c, k;
    bit          found;
    found = 1'b0;
    for (c = 0; c < N_CLASSES; c++) begin
      for (k = 0; k < due_q[c].size(); k++) begin
        if (due_q[c][k] == t) begin
          due_q[c].delete(k);
          break;
        end
      end
    end
    rec_prio[t]   = prio;
    rec_rel[t]    = rel;
    rec_delay[t]  = delay;
    rec_mask[t]   = mask;
    rec_any[t]    = any;
    rec_posted[t] = '0;
    for (k = 0; k < suspended_q.size(); k++)
      if (suspended_q[k] == t) found = 1'b1;
    if (!found && suspended_q.size() < N_TASKS) suspended_q.push_back(t);
  endfunction

  // Apply one accepted item and form the result it causes
  function automatic sched_result_t schedule_item();
    logic [OUT_TASK_W-1:0] was_running;
    sched_result_t         res;
    was_running = running_now;
    if (in_ch.mode == MODE_TICK) begin
      if (advance_tick()) pick_running();
    end else begin
      load_record(in_ch.task_index, in_ch.priority_class, in_ch.release_time,
                  in_ch.delay_ticks, in_ch.wait_mask, in_ch.wait_any);
      pick_running();
    end
    res.switch_needed = (running_now != was_running);
    res.running_task  = running_now;
    res.left_task     = left_now;
    return res;
  endfunction

  task automatic report_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      fail_cnt++;
    end
  endtask

  // Predict on input items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t exp_res;
    if (!rst_ni) begin
      reset_schedule();
      sched_results_q.delete();
      fail_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) sched_results_q.push_back(schedule_item());
      if (out_ch.valid && out_ch.ready) begin
        if (sched_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got switch %0d run %0d left %0d",
                   $time, out_ch.switch_needed, out_ch.running_task, out_ch.left_task);
          fail_cnt++;
        end else begin
          exp_res = sched_results_q.pop_front();
          report_field("switch_needed", exp_res.switch_needed, out_ch.switch_needed);
          report_field("running_task", exp_res.running_task, out_ch.running_task);
          report_field("left_task", exp_res.left_task, out_ch.left_task);
        end
      end
      fail_count_o <= fail_cnt;
      pending_o    <= sched_results_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top of the task scheduler: clock, reset, item stimulus and verdict.
// Depends on tets_pkg, the channel interfaces, the scheduler and tets_sched_checker.

module tb_top;
  import tets_pkg::*;

  localparam int unsigned NUM_ITEMS      = 1450;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 50;

  typedef struct packed {
    logic                  mode;
    logic [TASK_IDX_W-1:0] task_index;
    logic [PRIO_W-1:0]     prio;
    logic [REL_TIME_W-1:0] rel_time;
    logic [DELAY_W-1:0]    delay;
    logic [MASK_W-1:0]     mask;
    logic                  wait_any;
  } sched_item_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_ready = 1'b0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [TIME_BITS_DEF-1:0] now_time = '1;

  rx_style_e   rx_style = RX_ALWAYS;
  int unsigned rx_phase_left = 0;
  int unsigned rx_period = 1;
  int unsigned rx_count = 0;

  tets_in_if  in_if ();
  tets_out_if out_if ();

  assign out_if.ready = rx_ready;

  tick_event_task_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tets_sched_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: switch between stall patterns in phases of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready      <= 1'b0;
      rx_phase_left <= 0;
      rx_count      <= 0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style      <= rx_style_e'($urandom_range(0, 3));
        rx_phase_left <= $urandom_range(16, 160);
        rx_period     <= $urandom_range(2, 24);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      rx_count <= rx_count + 1;
      case (rx_style)
        RX_ALWAYS:   rx_ready <= 1'b1;
        RX_COIN:     rx_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:   rx_ready <= ($urandom_range(0, 7) != 0);
        RX_PERIODIC: rx_ready <= (rx_count % rx_period == 0);
      endcase
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Tick item; the fields it ignores carry random values
  function automatic sched_item_t tick_item();
    sched_item_t item;
    item.mode       = MODE_TICK;
    item.task_index = TASK_IDX_W'($urandom);
    item.prio       = PRIO_W'($urandom);
    item.rel_time   = REL_TIME_W'($urandom);
    item.delay      = DELAY_W'($urandom);
    item.mask       = MASK_W'($urandom);
    item.wait_any   = 1'($urandom);
    return item;
  endfunction

  function automatic sched_item_t load_item(input logic [TASK_IDX_W-1:0] t,
                                            input logic [PRIO_W-1:0]     prio,
                                            input logic [REL_TIME_W-1:0] rel,
                                            input logic [DELAY_W-1:0]    delay,
                                            input logic [MASK_W-1:0]     mask,
                                            input logic                  any);
    sched_item_t item;
    item.mode       = MODE_LOAD;
    item.task_index = t;
    item.prio       = prio;
    item.rel_time   = rel;
    item.delay      = delay;
    item.mask       = mask;
    item.wait_any   = any;
    return item;
  endfunction

  // Load with timing near the current time unless fully random is asked
  function automatic sched_item_t random_load(input bit wide);
    sched_item_t item;
    item      = tick_item();
    item.mode = MODE_LOAD;
    if (!wide) begin
      item.rel_time = ($urandom_range(0, 7) == 0) ? REL_TIME_W'($urandom)
                                                  : now_time + REL_TIME_W'($urandom_range(1, 8));
      item.delay    = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom)
                                                  : DELAY_W'($urandom_range(0, 8));
      item.mask     = ($urandom_range(0, 5) == 0) ? MASK_W'($urandom)
                                                  : MASK_W'($urandom_range(0, 3));
    end
    return item;
  endfunction

  // Drive one item in bursts with random gaps; return once it is accepted
  task automatic send_item(input sched_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= item.mode;
    in_if.task_index     <= item.task_index;
    in_if.priority_class <= item.prio;
    in_if.release_time   <= item.rel_time;
    in_if.delay_ticks    <= item.delay;
    in_if.wait_mask      <= item.mask;
    in_if.wait_any       <= item.wait_any;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    items_sent++;
    if (item.mode == MODE_TICK) now_time++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic hold_off();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    in_if.valid          <= 1'b0;
    in_if.mode           <= MODE_TICK;
    in_if.task_index     <= '0;
    in_if.priority_class <= '0;
    in_if.release_time   <= '0;
    in_if.delay_ticks    <= '0;
    in_if.wait_mask      <= '0;
    in_if.wait_any       <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First tick releases every task at time zero
    send_item(tick_item());
    // Absolute timer in the top class preempts
    send_item(load_item(3'd3, 2'd3, now_time + 8'd2, 8'd0, 8'h01, 1'b1));
    send_item(tick_item());
    send_item(tick_item());
    // Delay event of one tick
    send_item(load_item(3'd5, 2'd2, 8'd0, 8'd1, 8'h02, 1'b1));
    send_item(tick_item());
    // Pull the running task back; empty all-of mask releases on the next tick
    send_item(load_item(3'd3, 2'd0, 8'd0, 8'd0, 8'h00, 1'b0));
    // Extremes: mask bits that never post; empty any-of mask never releases
    send_item(load_item(3'd1, 2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_item(load_item(3'd2, 2'd3, now_time + 8'd1, 8'd0, 8'h00, 1'b1));
    // All-of wait on both events landing on the same tick
    send_item(load_item(3'd6, 2'd1, now_time + 8'd3, 8'd3, 8'h03, 1'b0));
    // Adjacent suspended tasks released on one tick
    send_item(load_item(3'd7, 2'd2, now_time + 8'd1, 8'd0, 8'h01, 1'b1));
    send_item(load_item(3'd0, 2'd2, now_time + 8'd1, 8'd0, 8'h01, 1'b1));
    // Reload a task that is already suspended
    send_item(load_item(3'd4, 2'd3, now_time + 8'd5, 8'd0, 8'h01, 1'b1));
    send_item(load_item(3'd4, 2'd3, now_time + 8'd2, 8'd0, 8'h01, 1'b1));
    // All-of on a delay that never comes
    send_item(load_item(3'd5, 2'd0, 8'h00, 8'd0, 8'h03, 1'b0));
    repeat (5) send_item(tick_item());
    hold_off();

    // Random part: load-then-tick sequences, noise and long tick runs
    while (items_sent < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        repeat ($urandom_range(1, 3)) send_item(random_load(1'b0));
        repeat ($urandom_range(1, 8)) send_item(tick_item());
      end else if (pick < 90) begin
        send_item($urandom_range(0, 1) ? tick_item() : random_load(1'b1));
      end else if (pick < 98) begin
        repeat ($urandom_range(8, 40)) send_item(tick_item());
      end else begin
        hold_off();
      end
    end

    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
